// ===== design/lcdms_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lcdms_pkg
// Shared types and constants of the LCD mode timing sequencer.
// ----------------------------------------------------------------------------
package lcdms_pkg;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } lcd_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } seq_state_t;

  localparam int ACCUM_W = 11;
  localparam int DUR_W   = 10;
  localparam int LINE_W  = 8;
  localparam int ELAP_W  = 6;

  localparam logic [2:0] REG_LINE_CMP  = 3'd0;
  localparam logic [2:0] REG_IRQ_EN    = 3'd1;
  localparam logic [2:0] REG_OAM_TICKS = 3'd2;
  localparam logic [2:0] REG_XFER_TICKS = 3'd3;
  localparam logic [2:0] REG_HBL_TICKS = 3'd4;
  localparam logic [2:0] REG_LINE_TICKS = 3'd5;

  localparam logic [DUR_W-1:0] OAM_TICKS_RST  = 10'd80;
  localparam logic [DUR_W-1:0] XFER_TICKS_RST = 10'd172;
  localparam logic [DUR_W-1:0] HBL_TICKS_RST  = 10'd204;
  localparam logic [DUR_W-1:0] LINE_TICKS_RST = 10'd456;

  localparam logic [LINE_W-1:0] LINES_VISIBLE = 8'd144;
  localparam logic [LINE_W-1:0] LINES_TOTAL   = 8'd154;

  localparam int IRQ_HBLANK = 0;
  localparam int IRQ_VBLANK = 1;
  localparam int IRQ_OAM    = 2;
  localparam int IRQ_COINC  = 3;

endpackage
`default_nettype wire

// ===== design/lcdms_mod.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lcdms_mod
// Iterative remainder unit: restoring division, four quotient bits a cycle.
// ----------------------------------------------------------------------------
module lcdms_mod
  import lcdms_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [ACCUM_W-1:0] dividend,
  input  wire logic [DUR_W-1:0]   divisor,
  output logic                    done,
  output logic [DUR_W-1:0]        rem
);

  localparam int STEPS   = 4;
  localparam int CYCLES  = (ACCUM_W + STEPS - 1) / STEPS;
  localparam int SHIFT_W = CYCLES * STEPS;
  localparam int CNT_W   = $clog2(CYCLES + 1);

  logic [SHIFT_W-1:0] shift_r, shift_nxt;
  logic [DUR_W-1:0]   rem_r, rem_nxt;
  logic [DUR_W-1:0]   div_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [DUR_W-1:0]   step_rem;
  logic [DUR_W:0]     trial;

  always_comb begin
    step_rem = rem_r;
    trial    = '0;
    for (int i = 0; i < STEPS; i++) begin
      trial = {step_rem, shift_r[SHIFT_W-1-i]};
      if (trial >= {1'b0, div_r}) begin
        trial = trial - {1'b0, div_r};
      end
      step_rem = trial[DUR_W-1:0];
    end
  end

  always_comb begin
    shift_nxt = shift_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (start) begin
      shift_nxt = {{(SHIFT_W-ACCUM_W){1'b0}}, dividend};
      rem_nxt   = '0;
      cnt_nxt   = CNT_W'(CYCLES - 1);
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      shift_nxt = shift_r << STEPS;
      rem_nxt   = step_rem;
      cnt_nxt   = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    rem_r   <= rem_nxt;
    if (start) begin
      div_r <= divisor;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

// ===== design/lcd_mode_sequencer_core.sv =====
// Flow: an input word is taken in IDLE; its result word is registered from
// DONE, with state DIV between them while the remainder unit runs when a
// period of nonzero length ends (not when no period ends or it has zero length).
// No new word is taken until the result register, which waits on out_tready,
// has taken the last result.
// Reset: synchronous active-low; control and configuration registers return
// to defaults, mode is OAM search, line 0, VRAM open, OAM closed.
`default_nettype none
// ----------------------------------------------------------------------------
// lcd_mode_sequencer_core
// LCD mode timing sequencer with APB configuration and stream ports.
// ----------------------------------------------------------------------------
module lcd_mode_sequencer_core
  import lcdms_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [5:0] elapsed_ticks
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,   // [1:0] lcd_mode, [9:2] current_line,
                                        // [10] coincidence, [11] vblank_irq,
                                        // [12] stat_irq, [13] vram_accessible,
                                        // [14] oam_accessible
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  seq_state_t state_r, state_nxt;

  logic [LINE_W-1:0]  line_cmp_r;
  logic [3:0]         irq_en_r;
  logic [DUR_W-1:0]   oam_ticks_r, xfer_ticks_r, hbl_ticks_r, line_ticks_r;

  logic [ACCUM_W-1:0] accum_r;
  logic               hit_r;
  lcd_mode_t          mode_r, mode_nxt;
  logic [LINE_W-1:0]  line_r, line_nxt;
  logic               coinc_r, coinc_nxt;
  logic               vram_r, vram_nxt;
  logic               oam_r, oam_nxt;
  logic               vb_nxt, st_nxt;
  logic               out_valid_r;
  logic [15:0]        out_data_r;

  logic               accept, out_free, cfg_wr;
  logic [2:0]         cfg_idx;
  logic [ACCUM_W-1:0] sum;
  logic [DUR_W-1:0]   cur_dur;
  logic               hit, div_start, div_done;
  logic [DUR_W-1:0]   div_rem;
  logic [LINE_W-1:0]  line_inc;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_cmp_r   <= '0;
      irq_en_r     <= '0;
      oam_ticks_r  <= OAM_TICKS_RST;
      xfer_ticks_r <= XFER_TICKS_RST;
      hbl_ticks_r  <= HBL_TICKS_RST;
      line_ticks_r <= LINE_TICKS_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_LINE_CMP:   line_cmp_r   <= cfg_pwdata[LINE_W-1:0];
        REG_IRQ_EN:     irq_en_r     <= cfg_pwdata[3:0];
        REG_OAM_TICKS:  oam_ticks_r  <= cfg_pwdata[DUR_W-1:0];
        REG_XFER_TICKS: xfer_ticks_r <= cfg_pwdata[DUR_W-1:0];
        REG_HBL_TICKS:  hbl_ticks_r  <= cfg_pwdata[DUR_W-1:0];
        REG_LINE_TICKS: line_ticks_r <= cfg_pwdata[DUR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_LINE_CMP:   cfg_prdata = {24'd0, line_cmp_r};
      REG_IRQ_EN:     cfg_prdata = {28'd0, irq_en_r};
      REG_OAM_TICKS:  cfg_prdata = {22'd0, oam_ticks_r};
      REG_XFER_TICKS: cfg_prdata = {22'd0, xfer_ticks_r};
      REG_HBL_TICKS:  cfg_prdata = {22'd0, hbl_ticks_r};
      REG_LINE_TICKS: cfg_prdata = {22'd0, line_ticks_r};
      default:        cfg_prdata = '0;
    endcase
  end

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign sum       = accum_r + {{(ACCUM_W-ELAP_W){1'b0}}, in_tdata[ELAP_W-1:0]};

  always_comb begin
    case (mode_r)
      MODE_OAM:    cur_dur = oam_ticks_r;
      MODE_XFER:   cur_dur = xfer_ticks_r;
      MODE_HBLANK: cur_dur = hbl_ticks_r;
      default:     cur_dur = line_ticks_r;
    endcase
  end

  assign hit       = sum > {1'b0, cur_dur};
  assign div_start = accept && hit && (cur_dur != '0);

  lcdms_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum),
    .divisor  (cur_dur),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = div_start ? ST_DIV : ST_DONE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign line_inc = line_r + 1'b1;

  always_comb begin
    mode_nxt  = mode_r;
    line_nxt  = line_r;
    coinc_nxt = coinc_r;
    vram_nxt  = vram_r;
    oam_nxt   = oam_r;
    vb_nxt    = 1'b0;
    st_nxt    = 1'b0;
    if (hit_r) begin
      case (mode_r)
        MODE_OAM: begin
          mode_nxt = MODE_XFER;
          vram_nxt = 1'b0;
        end
        MODE_XFER: begin
          mode_nxt  = MODE_HBLANK;
          vram_nxt  = 1'b1;
          oam_nxt   = 1'b1;
          coinc_nxt = (line_r == line_cmp_r);
          st_nxt    = irq_en_r[IRQ_HBLANK] || (coinc_nxt && irq_en_r[IRQ_COINC]);
        end
        MODE_HBLANK: begin
          line_nxt = line_inc;
          if (line_inc == LINES_VISIBLE) begin
            mode_nxt = MODE_VBLANK;
            vb_nxt   = 1'b1;
            st_nxt   = irq_en_r[IRQ_VBLANK];
          end else begin
            mode_nxt = MODE_OAM;
            oam_nxt  = 1'b0;
            st_nxt   = irq_en_r[IRQ_OAM];
          end
        end
        default: begin
          line_nxt = line_inc;
          if (line_inc == LINES_TOTAL) begin
            line_nxt = '0;
            mode_nxt = MODE_OAM;
            oam_nxt  = 1'b0;
            st_nxt   = irq_en_r[IRQ_OAM];
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      accum_r     <= '0;
      hit_r       <= 1'b0;
      mode_r      <= MODE_OAM;
      line_r      <= '0;
      coinc_r     <= 1'b0;
      vram_r      <= 1'b1;
      oam_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        hit_r   <= hit;
        accum_r <= (hit && (cur_dur == '0)) ? '0 : sum;
      end else if (div_done) begin
        accum_r <= {1'b0, div_rem};
      end
      if ((state_r == ST_DONE) && out_free) begin
        mode_r      <= mode_nxt;
        line_r      <= line_nxt;
        coinc_r     <= coinc_nxt;
        vram_r      <= vram_nxt;
        oam_r       <= oam_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_DONE) && out_free) begin
      out_data_r <= {1'b0, oam_nxt, vram_nxt, st_nxt, vb_nxt, coinc_nxt, line_nxt,
                     mode_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

// ===== design/lcdms_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lcdms_checker
// Port-level checks of the LCD mode timing sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module lcdms_checker
  import lcdms_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[9:2] < LINES_TOTAL)
    else $error("line counter out of range");

  a_vblank_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[11] |->
      out_tdata[1:0] == MODE_VBLANK && out_tdata[9:2] == LINES_VISIBLE)
    else $error("vblank request outside vblank entry");

  a_hblank_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == MODE_HBLANK |-> out_tdata[13] && out_tdata[14])
    else $error("memory closed in hblank");

  a_xfer_closed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == MODE_XFER |-> !out_tdata[13] && !out_tdata[14])
    else $error("memory open in pixel transfer");

endmodule

bind lcd_mode_sequencer_core lcdms_checker u_lcdms_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
